// ----- rtl/core/ip_range_policy_table_core_defines.svh -----
// ----------------------------------------------------------------------------
// ip_range_policy_table_core_defines
// assertion macros used by the range table core
// ----------------------------------------------------------------------------
`ifndef IP_RANGE_POLICY_TABLE_CORE_DEFINES_SVH
`define IP_RANGE_POLICY_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked after reset is released
`define IPRPT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("iprpt assertion failed");

// next-cycle implication, checked after reset is released
`define IPRPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("iprpt assertion failed");

`endif

// ----- rtl/core/iprpt_pkg.sv -----
// ----------------------------------------------------------------------------
// iprpt_pkg
// types, sizes and codes for the ip range policy table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iprpt_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LIMIT_W  = 9;
    localparam int CMP_W    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] ip_address;
        logic [31:0] range_low;
        logic [31:0] range_high;
        logic [15:0] identity_tag;
        logic [31:0] policy_number;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_identity;
        logic [31:0] found_policy;
    } t_out_word;

    typedef struct packed {
        logic [31:0] low;
        logic [31:0] high;
        logic [15:0] tag;
        logic [31:0] policy;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           entry;
    } t_wr_req;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_rd_req;

endpackage

`default_nettype wire

// ----- rtl/core/iprpt_store.sv -----
// ----------------------------------------------------------------------------
// iprpt_store
// entry memory: one write port, one read port with registered data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iprpt_store
    import iprpt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire t_wr_req i_wr,
    input  wire t_rd_req i_rd,
    output t_entry       o_rd_entry
);

    t_entry r_mem [CAPACITY];
    t_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_entry <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule

`default_nettype wire

// ----- rtl/core/iprpt_cmp.sv -----
// ----------------------------------------------------------------------------
// iprpt_cmp
// range compare: low <= address <= high, both bounds inclusive
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iprpt_cmp
    import iprpt_pkg::*;
(
    input  wire logic [31:0] i_addr,
    input  wire t_entry      i_entry,
    output logic             o_hit
);

    // an inverted range fails one of the two tests and never hits
    assign o_hit = (i_entry.low <= i_addr) && (i_addr <= i_entry.high);

endmodule

`default_nettype wire

// ----- rtl/core/ip_range_policy_table_core.sv -----
// ----------------------------------------------------------------------------
// ip_range_policy_table_core
// ipv4 range table with append, newest-first lookup and clear
//
//   channel  direction  handshake                 word
//   in       input      i_in_valid / o_in_ready   i_in_word  (t_in_word)
//   out      output     o_out_valid / i_out_ready o_out_word (t_out_word)
//   cfg      input      i_cfg_valid / o_cfg_ready i_cfg_data (entry limit)
//
// add, clear and unused modes load the result register on accept and go to S_DONE.
// lookup of an empty table goes to S_DONE at once; otherwise S_SCAN reads the
// entries newest first until a hit or the oldest one: the one read port of the
// entry memory feeds the compare one entry a cycle.
// one word is in flight at a time; in is not ready until its result is loaded into out.
// a result waiting on out does not block the next accept.
// reset zeroes the entry count and sets the limit to 256; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ip_range_policy_table_core_defines.svh"

module ip_range_policy_table_core
    import iprpt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_word           i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_word               o_out_word,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [LIMIT_W-1:0] i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]         r_state,     n_state;
    logic [CNT_W-1:0]   r_count,     n_count;
    logic [LIMIT_W-1:0] r_limit,     n_limit;
    logic [IDX_W-1:0]   r_pos,       n_pos;
    logic               r_chk_vld,   n_chk_vld;
    logic               r_chk_last,  n_chk_last;
    logic [31:0]        r_addr,      n_addr;
    t_out_word          r_res,       n_res;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out_word,  n_out_word;

    t_wr_req wr_req;
    t_rd_req rd_req;
    t_entry  rd_entry;
    logic    hit;
    logic    in_acc;
    logic    full;
    logic    out_free;

    iprpt_store u_store (
        .i_clk      (i_clk),
        .i_wr       (wr_req),
        .i_rd       (rd_req),
        .o_rd_entry (rd_entry)
    );

    iprpt_cmp u_cmp (
        .i_addr  (r_addr),
        .i_entry (rd_entry),
        .o_hit   (hit)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    // a limit above capacity is capped by the second test
    assign full     = (CMP_W'(r_count) >= CMP_W'(r_limit))
                   || (r_count == CNT_W'(CAPACITY));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_limit     = r_limit;
        n_pos       = r_pos;
        n_chk_vld   = r_chk_vld;
        n_chk_last  = r_chk_last;
        n_addr      = r_addr;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;

        wr_req.en           = 1'b0;
        wr_req.addr         = r_count[IDX_W-1:0];
        wr_req.entry.low    = i_in_word.range_low;
        wr_req.entry.high   = i_in_word.range_high;
        wr_req.entry.tag    = i_in_word.identity_tag;
        wr_req.entry.policy = i_in_word.policy_number;
        rd_req.en           = 1'b0;
        rd_req.addr         = r_pos;

        if (i_cfg_valid) begin
            n_limit = i_cfg_data;
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res   = '0;
                    n_state = S_DONE;
                    unique case (i_in_word.mode)
                        MODE_ADD: begin
                            if (full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                wr_req.en = 1'b1;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        MODE_LOOKUP: begin
                            n_addr = i_in_word.ip_address;
                            if (r_count == '0) begin
                                n_res.status = ST_MISS;
                            end else begin
                                n_pos     = IDX_W'(r_count - 1'b1);
                                n_chk_vld = 1'b0;
                                n_state   = S_SCAN;
                            end
                        end
                        MODE_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_res.status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // check the entry read last cycle; unless it hits or is the oldest, fetch the next one
                if (r_chk_vld && hit) begin
                    n_res.status         = ST_OK;
                    n_res.found_identity = rd_entry.tag;
                    n_res.found_policy   = rd_entry.policy;
                    n_state              = S_DONE;
                end else if (r_chk_vld && r_chk_last) begin
                    n_res.status = ST_MISS;
                    n_state      = S_DONE;
                end else begin
                    rd_req.en  = 1'b1;
                    n_chk_vld  = 1'b1;
                    n_chk_last = (r_pos == '0);
                    n_pos      = r_pos - 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_limit     <= LIMIT_W'(256);
            r_pos       <= '0;
            r_chk_vld   <= 1'b0;
            r_chk_last  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_limit     <= n_limit;
            r_pos       <= n_pos;
            r_chk_vld   <= n_chk_vld;
            r_chk_last  <= n_chk_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    `IPRPT_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY))
    `IPRPT_ASSERT_NEXT(a_add_count,
        in_acc && (i_in_word.mode == MODE_ADD) && !full,
        r_count == CNT_W'($past(r_count) + 1'b1))
    `IPRPT_ASSERT_NEXT(a_clear_count,
        in_acc && (i_in_word.mode == MODE_CLEAR),
        r_count == '0)
    `IPRPT_ASSERT_NEXT(a_hit_done,
        (r_state == S_SCAN) && r_chk_vld && hit,
        (r_state == S_DONE) && (r_res.status == ST_OK))

endmodule

`default_nettype wire

// ----- sim/iprpt_lookup_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprpt_lookup_checker
// watches the in, out and cfg channels of the range table, keeps its own copy
// of the table, predicts the answer to every accepted word and compares it
// with the answers coming out, oldest first
// ----------------------------------------------------------------------------

module iprpt_lookup_checker
    import iprpt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire t_in_word           i_in_word,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire t_out_word          i_out_word,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [LIMIT_W-1:0] i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending
);

    logic [31:0] range_lo  [CAPACITY];
    logic [31:0] range_hi  [CAPACITY];
    logic [15:0] range_tag [CAPACITY];
    logic [31:0] range_pol [CAPACITY];
    int          stored = 0;
    int          limit  = 256;
    int          fails  = 0;
    t_out_word   pending_answers [$];

    // applies one word to the table copy and returns the answer it gives
    function automatic t_out_word apply_word(input t_in_word w);
        t_out_word ans;
        int        lim;
        int        pos;
        bit        hit;
        ans        = '0;
        ans.status = ST_OK;
        lim        = (limit > CAPACITY) ? CAPACITY : limit;
        case (w.mode)
            MODE_ADD: begin
                if (stored >= lim) begin
                    ans.status = ST_FULL;
                end else begin
                    range_lo[stored]  = w.range_low;
                    range_hi[stored]  = w.range_high;
                    range_tag[stored] = w.identity_tag;
                    range_pol[stored] = w.policy_number;
                    stored++;
                end
            end
            MODE_LOOKUP: begin
                pos = stored;
                hit = 1'b0;
                // newest entry first, first hit wins
                while (pos > 0 && !hit) begin
                    pos--;
                    if (range_lo[pos] <= w.ip_address &&
                        w.ip_address <= range_hi[pos]) begin
                        hit                = 1'b1;
                        ans.found_identity = range_tag[pos];
                        ans.found_policy   = range_pol[pos];
                    end
                end
                ans.status = hit ? ST_OK : ST_MISS;
            end
            MODE_CLEAR: begin
                stored = 0;
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            stored = 0;
            limit  = 256;
            pending_answers.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                limit = int'(i_cfg_data);
            end
            // answers are checked before the new word is queued
            if (i_out_valid && i_out_ready) begin
                if (pending_answers.size() == 0) begin
                    if (fails < 10) begin
                        $display("unexpected answer: status %0d id %h policy %h",
                                 i_out_word.status, i_out_word.found_identity,
                                 i_out_word.found_policy);
                    end
                    fails++;
                end else begin
                    want = pending_answers.pop_front();
                    if (i_out_word.status !== want.status ||
                        i_out_word.found_identity !== want.found_identity ||
                        i_out_word.found_policy !== want.found_policy) begin
                        if (fails < 10) begin
                            $display({"answer mismatch: expected status %0d id %h ",
                                      "policy %h, got status %0d id %h policy %h"},
                                     want.status, want.found_identity,
                                     want.found_policy, i_out_word.status,
                                     i_out_word.found_identity,
                                     i_out_word.found_policy);
                        end
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_answers.push_back(apply_word(i_in_word));
            end
        end
        o_pending    <= pending_answers.size();
        o_fail_count <= fails;
    end

endmodule

// ----- sim/ip_range_policy_table_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_range_policy_table_core_tb
// drives adds, lookups, clears and limit changes into the range table with
// random gaps on both sides and a long output stall; the checker beside the
// block predicts every answer and the top gives the verdict
// ----------------------------------------------------------------------------

module ip_range_policy_table_core_tb;
    import iprpt_pkg::*;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int         HOLD_CYCLES = 500;
    localparam int         WORD_GOAL   = 900;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    t_in_word           in_word   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_out_word          out_word;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data  = '0;
    int                 n_fail;
    int                 n_pending;

    int          sent         = 0;
    bit          steady       = 1'b0;
    bit          hold_pending = 1'b0;
    bit          squeezed     = 1'b0;
    logic [31:0] shadow_lo [256];
    logic [31:0] shadow_hi [256];
    int          shadow_n     = 0;

    always #1 clk = ~clk;

    ip_range_policy_table_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    iprpt_lookup_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (n_fail),
        .o_pending    (n_pending)
    );

    // mostly back to back, a few short gaps, rarely a long one
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // random content everywhere, the caller sets what the mode uses
    function automatic t_in_word mk_word(input logic [1:0] m);
        t_in_word w;
        w.mode          = m;
        w.ip_address    = $urandom;
        w.range_low     = $urandom;
        w.range_high    = $urandom;
        w.identity_tag  = 16'($urandom);
        w.policy_number = $urandom;
        return w;
    endfunction

    function automatic logic [31:0] pick_addr();
        int          k;
        logic [31:0] lo;
        logic [31:0] hi;
        if (shadow_n == 0 || $urandom_range(0, 9) < 3) begin
            return $urandom;
        end
        k  = $urandom_range(0, shadow_n - 1);
        lo = shadow_lo[k];
        hi = shadow_hi[k];
        case ($urandom_range(0, 4))
            0: return lo;
            1: return hi;
            2: return lo - 32'd1;
            3: return hi + 32'd1;
            default: return (hi >= lo) ? lo + $urandom_range(0, hi - lo) : lo;
        endcase
    endfunction

    task automatic make_range(output logic [31:0] lo, output logic [31:0] hi);
        int          r;
        logic [31:0] base;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: base = 32'h0A00_0000;
            1: base = 32'hC0A8_0000;
            2: base = 32'hAC10_0000;
            default: base = 32'hFFFF_F000;
        endcase
        lo = base + $urandom_range(0, 1023);
        if (r < 60) begin
            hi = lo + $urandom_range(0, 15);
        end else if (r < 80) begin
            hi = lo + $urandom_range(16, 2047);
        end else if (r < 90) begin
            hi = lo - $urandom_range(1, 64);
        end else if (r < 97) begin
            lo = $urandom;
            hi = $urandom;
        end else begin
            lo = 32'h0000_0000;
            hi = 32'hFFFF_FFFF;
        end
    endtask

    // valid stays high across back-to-back words, lowered only before a gap
    task automatic send_word(input t_in_word w);
        int gap;
        gap = pick_gap(steady);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    task automatic send_add(input logic [31:0] lo, input logic [31:0] hi,
                            input logic [15:0] tag, input logic [31:0] pol);
        t_in_word w;
        w               = mk_word(MODE_ADD);
        w.range_low     = lo;
        w.range_high    = hi;
        w.identity_tag  = tag;
        w.policy_number = pol;
        send_word(w);
    endtask

    task automatic send_lookup(input logic [31:0] addr);
        t_in_word w;
        w            = mk_word(MODE_LOOKUP);
        w.ip_address = addr;
        send_word(w);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (n_pending != 0);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls, long ready stretches, and one long hold-off
    initial begin
        int lo_len;
        int hi_len;
        wait (rst_n);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                lo_len       = HOLD_CYCLES;
            end else begin
                lo_len = pick_gap(1'b0);
            end
            if (lo_len > 0) begin
                out_ready <= 1'b0;
                repeat (lo_len) @(posedge clk);
            end
            out_ready <= 1'b1;
            hi_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 8);
            repeat (hi_len) @(posedge clk);
        end
    end

    initial begin
        int          phase;
        int          n;
        int          i;
        int          r;
        int          add_pct;
        bit          fill;
        logic [8:0]  lim;
        logic [31:0] lo;
        logic [31:0] hi;
        t_in_word    w;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, field extremes, overlap, inverted range
        send_lookup(32'h0000_0000);
        send_add(32'h0000_0000, 32'h0000_0000, 16'h0000, 32'h0000_0000);
        send_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_add(32'd10, 32'd20, 16'h0001, 32'h0000_0001);
        send_add(32'd15, 32'd100, 16'h0003, 32'h8000_0003);
        send_add(32'd50, 32'd40, 16'h0004, 32'h0000_0004);
        send_lookup(32'h0000_0000);
        send_lookup(32'hFFFF_FFFF);
        send_lookup(32'd15);
        send_lookup(32'd20);
        send_lookup(32'd21);
        send_lookup(32'd101);
        send_lookup(32'd45);
        send_lookup(32'd9);
        send_word(mk_word(MODE_SPARE));
        // limit dropped below the count: entries stay searchable, adds refused
        set_limit(9'd0);
        send_add(32'd200, 32'd300, 16'h0005, 32'h0000_0005);
        send_lookup(32'd16);
        send_word(mk_word(MODE_CLEAR));
        send_lookup(32'd16);
        send_add(32'd200, 32'd300, 16'h0006, 32'h0000_0006);
        // limit above capacity
        set_limit(9'd511);
        send_add(32'd200, 32'd300, 16'h0007, 32'h0000_0007);
        send_lookup(32'd250);

        phase = 0;
        while (sent < WORD_GOAL) begin
            case (phase)
                0: lim = 9'd511;
                1: lim = 9'd256;
                2: lim = 9'd0;
                3: lim = 9'd1;
                default: begin
                    case ($urandom_range(0, 6))
                        0: lim = 9'd2;
                        1: lim = 9'd8;
                        2: lim = 9'd255;
                        3: lim = 9'd257;
                        4: lim = 9'd31;
                        default: lim = 9'($urandom_range(0, 511));
                    endcase
                end
            endcase
            set_limit(lim);
            fill    = (phase == 0);
            steady  = ($urandom_range(0, 3) == 0);
            n       = fill ? 300 : $urandom_range(40, 110);
            add_pct = fill ? 85 : 40;
            if (fill || $urandom_range(0, 1) == 1) begin
                send_word(mk_word(MODE_CLEAR));
                shadow_n = 0;
            end
            for (i = 0; i < n; i++) begin
                if (!squeezed && sent >= 400) begin
                    squeezed     = 1'b1;
                    hold_pending = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < add_pct) begin
                    make_range(lo, hi);
                    if (shadow_n < 256) begin
                        shadow_lo[shadow_n] = lo;
                        shadow_hi[shadow_n] = hi;
                        shadow_n++;
                    end
                    send_add(lo, hi, 16'($urandom), $urandom);
                end else if (r < 95 || (fill && r < 98)) begin
                    send_lookup(pick_addr());
                end else if (r < 98) begin
                    send_word(mk_word(MODE_CLEAR));
                    shadow_n = 0;
                end else begin
                    w = mk_word(MODE_SPARE);
                    send_word(w);
                end
            end
            phase++;
        end

        wait_drained();
        // tail for any stray answer after the last one expected
        repeat (40) @(posedge clk);
        if (n_fail == 0 && n_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
